@@ rtl/core/tks_pkg.sv @@
// Shared types and constants for the trajectory Kalman smoother.
`default_nettype none
package tks_pkg;
  localparam int AXES      = 3;
  localparam int REG_W     = 20;
  localparam int COV_W     = 24;
  localparam int PATH_W    = 48;
  localparam int MOVE_W    = 32;
  localparam logic [0:0] REG_PNOISE = 1'b0;
  localparam logic [0:0] REG_MNOISE = 1'b1;

  typedef struct packed {
    logic start;
    logic first;
  } lane_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/tks_lane.sv @@
// One axis: trajectory, gain division, estimate and covariance update.
`default_nettype none
module tks_lane
  import tks_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lane_ctl_t                ctl,
  input  wire logic signed [MOVE_W-1:0] move,
  input  wire logic [REG_W-1:0]         q_noise,
  input  wire logic [REG_W-1:0]         r_noise,
  output logic                          done,
  output logic signed [MOVE_W-1:0]      result
);
  localparam int KW  = FRAC_BITS + 1;
  localparam int DW  = COV_W + 1;
  localparam int CW  = $clog2(KW + 1);
  localparam logic [COV_W-1:0] COV_ONE =
    (FRAC_BITS >= COV_W) ? {COV_W{1'b1}} : COV_W'(64'd1 << FRAC_BITS);
  localparam logic signed [PATH_W+1:0] PMAX = (PATH_W+2)'(64'h7FFF_FFFF_FFFF);
  localparam logic signed [PATH_W+1:0] PMIN = -PMAX - 1;
  localparam logic signed [PATH_W+1:0] OMAX = (PATH_W+2)'(64'h7FFF_FFFF);
  localparam logic signed [PATH_W+1:0] OMIN = -OMAX - 1;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_UPD, S_OUT} st_t;
  st_t st_r;
  logic signed [PATH_W-1:0] path_r, est_r;
  logic [COV_W-1:0]         cov_r, pp_r;
  logic [DW-1:0]            den_r;
  logic [DW-1:0]            rem_r;
  logic [KW-1:0]            k_r;
  logic [CW-1:0]            cnt_r;
  logic signed [MOVE_W-1:0] move_r;
  logic signed [PATH_W:0]   resid_r;
  logic [PATH_W+KW:0]       prod_r;
  logic [COV_W+KW:0]        cprod_r;
  logic signed [MOVE_W-1:0] res_r;

  // restoring division step: shift the remainder, try to subtract den
  logic [DW:0]   rsh;
  logic [DW+1:0] trial;
  assign rsh   = {rem_r, 1'b0};
  assign trial = {1'b0, rsh} - {2'b0, den_r};

  logic signed [PATH_W+1:0] psum, outv;
  logic [PATH_W-1:0]        mag;
  logic [PATH_W-1:0]        delta;
  logic signed [PATH_W-1:0] est_n;
  logic [COV_W:0]           ppsum;
  logic [COV_W-1:0]         pp_sat;
  assign psum   = (PATH_W+2)'(path_r) + (PATH_W+2)'(move);
  assign ppsum  = {1'b0, cov_r} + (COV_W+1)'(q_noise);
  assign pp_sat = ppsum[COV_W] ? {COV_W{1'b1}} : ppsum[COV_W-1:0];
  assign mag    = resid_r[PATH_W] ? PATH_W'(-resid_r) : PATH_W'(resid_r);
  assign delta  = PATH_W'(prod_r >> FRAC_BITS);
  assign est_n  = resid_r[PATH_W] ? est_r - $signed(delta) : est_r + $signed(delta);
  assign outv   = (PATH_W+2)'(move_r) + (PATH_W+2)'(est_r) - (PATH_W+2)'(path_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      path_r <= '0;
      est_r <= '0;
      cov_r <= COV_ONE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (ctl.start) begin
            move_r <= move;
            if (ctl.first) begin
              path_r <= PATH_W'(move);
              est_r  <= '0;
              cov_r  <= COV_ONE;
              st_r   <= S_OUT;
            end else begin
              // saturate the trajectory and P+Q
              path_r <= (psum > PMAX) ? PATH_W'(PMAX) :
                        (psum < PMIN) ? PATH_W'(PMIN) : PATH_W'(psum);
              pp_r   <= pp_sat;
              den_r  <= DW'(pp_sat) + DW'(r_noise);
              // top quotient bit: pp reaches den only when R is zero
              rem_r  <= (r_noise == '0) ? '0 : DW'(pp_sat);
              k_r    <= {{(KW-1){1'b0}}, (r_noise == '0)};
              cnt_r  <= '0;
              st_r   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // one quotient bit per cycle for the FRAC_BITS fraction bits
          if (den_r == '0) begin
            k_r  <= '0;
            st_r <= S_MUL;
            resid_r <= (PATH_W+1)'(path_r) - (PATH_W+1)'(est_r);
          end else begin
            if (cnt_r == CW'(FRAC_BITS)) begin
              st_r <= S_MUL;
              resid_r <= (PATH_W+1)'(path_r) - (PATH_W+1)'(est_r);
            end else begin
              cnt_r <= cnt_r + 1'b1;
              k_r   <= {k_r[KW-2:0], ~trial[DW+1]};
              rem_r <= trial[DW+1] ? rsh[DW-1:0] : trial[DW-1:0];
            end
          end
        end
        S_MUL: begin
          prod_r  <= (PATH_W+KW+1)'(mag) * (PATH_W+KW+1)'(k_r);
          cprod_r <= (COV_W+KW+1)'((KW)'(64'd1 << FRAC_BITS) - k_r)
                     * (COV_W+KW+1)'(pp_r);
          st_r    <= S_UPD;
        end
        S_UPD: begin
          est_r <= est_n;
          cov_r <= COV_W'(cprod_r >> FRAC_BITS);
          st_r  <= S_OUT;
        end
        S_OUT: begin
          res_r <= (outv > OMAX) ? MOVE_W'(OMAX) :
                   (outv < OMIN) ? MOVE_W'(OMIN) : MOVE_W'(outv);
          done  <= 1'b1;
          st_r  <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // gain is at most 1.0, so FRAC_BITS + 1 quotient bits cover it
  assign result = res_r;
endmodule
`default_nettype wire

@@ rtl/core/trajectory_kalman_smoother.sv @@
// Top level: stream ports, three axis lanes and the result merge.
// A normal frame runs the per-lane radix-2 divider for the gain, which gives a zero
// gain without dividing when P+Q and R are both zero; a first frame skips the
// division. One transaction is in flight at a time, so a new one is taken only after
// the last result has been accepted on the output.
// Reset (rst_n, synchronous) clears trajectory and estimate, sets covariance
// to 1.0 and the noise registers to their defaults.
`default_nettype none
module trajectory_kalman_smoother
  import tks_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // move_x, move_y, move_angle
  input  wire logic         in_tuser,   // restart
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // fixed_x, fixed_y, fixed_angle
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);
  logic [REG_W-1:0] q_r, r_r;
  logic started_r, busy_r;
  logic [AXES-1:0] done;
  logic signed [MOVE_W-1:0] res [AXES];
  lane_ctl_t ctl;

  // take a transaction only when idle and the output slot is free
  assign in_tready = !busy_r && !out_tvalid;
  assign ctl.start = in_tvalid && in_tready;
  assign ctl.first = in_tuser || !started_r;

  genvar g;
  generate
    for (g = 0; g < AXES; g++) begin : g_lane
      tks_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .move($signed(in_tdata[g*MOVE_W +: MOVE_W])),
        .q_noise(q_r), .r_noise(r_r),
        .done(done[g]), .result(res[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= REG_W'(262);
      r_r <= REG_W'(16384);
      started_r <= 1'b0;
      busy_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_PNOISE) q_r <= cfg_data;
      if (cfg_we && cfg_index == REG_MNOISE) r_r <= cfg_data;
      if (ctl.start) begin
        busy_r <= 1'b1;
        started_r <= 1'b1;
      end
      // merge: lanes of one transaction finish in step
      if (done[0]) begin
        busy_r <= 1'b0;
        out_tvalid <= 1'b1;
        out_tdata <= {res[2], res[1], res[0]};
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
